### rtl/pcan_pkg.sv
// ----------------------------------------------------------------------------
// Path canonicalizer package
// Shared types, limits and byte codes for the lexical path canonicalizer.
// ----------------------------------------------------------------------------
package pcan_pkg;

  localparam int MAX_COMPONENTS = 62;
  localparam int MAX_LEN        = 4096;

  localparam int PTR_W   = $clog2(MAX_LEN + 1);
  localparam int DEPTH_W = $clog2(MAX_COMPONENTS + 1);
  localparam int STK_AW  = (MAX_COMPONENTS > 1) ? $clog2(MAX_COMPONENTS) : 1;
  localparam int POS_W   = 13;

  localparam int MAX_RES  = 4;
  localparam int RES_CW   = $clog2(MAX_RES + 1);
  localparam int RQ_DEPTH = 8;
  localparam int RQ_AW    = $clog2(RQ_DEPTH);
  localparam int RQ_CW    = $clog2(RQ_DEPTH + 1);

  localparam logic [7:0] CH_SEP = 8'h2F;
  localparam logic [7:0] CH_DOT = 8'h2E;

  typedef enum logic [1:0] {
    KIND_WRITE  = 2'd0,
    KIND_LENGTH = 2'd1,
    KIND_ERROR  = 2'd2
  } kind_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       last_char;
  } in_item_t;

  typedef struct packed {
    kind_t            kind;
    logic [POS_W-1:0] position;
    logic [7:0]       out_byte;
    logic             path_done;
  } out_item_t;

  typedef struct packed {
    logic [RES_CW-1:0]          cnt;
    out_item_t [MAX_RES-1:0]    items;
  } res_burst_t;

  typedef struct packed {
    logic             push;
    logic             pop;
    logic             clear;
    logic [PTR_W-1:0] val;
  } stk_ctl_t;

  typedef struct packed {
    logic [DEPTH_W-1:0] depth;
    logic [PTR_W-1:0]   top;
  } stk_stat_t;

endpackage

### rtl/pcan_stack.sv
// ----------------------------------------------------------------------------
// Component start stack
// Holds the top entry in a register and the rest in a memory, with the entry
// below the top prefetched every cycle, so a pop takes it as the new top.
// ----------------------------------------------------------------------------
module pcan_stack
  import pcan_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  stk_ctl_t  ctl,
  output stk_stat_t stat
);

  logic [PTR_W-1:0]   mem [MAX_COMPONENTS];
  logic [DEPTH_W-1:0] depth_r;
  logic [DEPTH_W-1:0] depth_nxt;
  logic [PTR_W-1:0]   top_r;
  logic [PTR_W-1:0]   top_nxt;
  logic [PTR_W-1:0]   rd_q_r;
  logic [PTR_W-1:0]   byp_val_r;
  logic               byp_r;
  logic [PTR_W-1:0]   below;
  logic               we;
  logic [STK_AW-1:0]  wa;
  logic [STK_AW-1:0]  ra;

  assign below = byp_r ? byp_val_r : rd_q_r;
  assign we    = ctl.push && !ctl.clear && (depth_r != '0);
  assign wa    = STK_AW'(depth_r - DEPTH_W'(1));

  always_comb begin
    priority if (ctl.clear) begin
      depth_nxt = '0;
    end else if (ctl.push) begin
      depth_nxt = depth_r + DEPTH_W'(1);
    end else if (ctl.pop) begin
      depth_nxt = depth_r - DEPTH_W'(1);
    end else begin
      depth_nxt = depth_r;
    end
  end

  always_comb begin
    priority if (ctl.push) begin
      top_nxt = ctl.val;
    end else if (ctl.pop) begin
      top_nxt = below;
    end else begin
      top_nxt = top_r;
    end
  end

  assign ra = (depth_nxt >= DEPTH_W'(2)) ? STK_AW'(depth_nxt - DEPTH_W'(2)) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r <= '0;
      byp_r   <= 1'b0;
    end else begin
      depth_r <= depth_nxt;
      byp_r   <= we;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= top_r;
    end
    rd_q_r    <= mem[ra];
    byp_val_r <= top_r;
    top_r     <= top_nxt;
  end

  assign stat.depth = depth_r;
  assign stat.top   = top_r;

endmodule

### rtl/pcan_engine.sv
// ----------------------------------------------------------------------------
// Path rewrite engine
// Classifies one path byte per cycle while go is high, updates the path state
// and emits the byte's buffer writes and, on a last byte, the length or error.
// ----------------------------------------------------------------------------
module pcan_engine
  import pcan_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       go,
  input  in_item_t   item,
  output res_burst_t burst
);

  stk_ctl_t         stk_ctl;
  stk_stat_t        stk_stat;

  logic [PTR_W-1:0] wp_r;
  logic [PTR_W-1:0] wp_nxt;
  logic [1:0]       held_r;
  logic [1:0]       held_nxt;
  logic             incomp_r;
  logic             incomp_nxt;
  logic             start_r;
  logic             start_nxt;
  logic             err_r;
  logic             err_nxt;

  logic [7:0]       seq [MAX_RES];
  logic [1:0]       nb;
  logic [1:0]       ne;
  logic             push;
  logic             pop;
  logic             full;
  logic [PTR_W-1:0] room;
  logic [PTR_W-1:0] wp_after;
  logic [PTR_W-1:0] len;

  assign full = stk_stat.depth >= DEPTH_W'(MAX_COMPONENTS);

  always_comb begin
    held_nxt   = held_r;
    incomp_nxt = incomp_r;
    start_nxt  = start_r;
    err_nxt    = err_r;
    push       = 1'b0;
    pop        = 1'b0;
    nb         = 2'd0;
    for (int k = 0; k < MAX_RES; k++) begin
      seq[k] = 8'h00;
    end
    if (!err_r) begin
      if (start_r) begin
        start_nxt = 1'b0;
      end
      priority if (start_r && item.ch == CH_SEP) begin
        nb     = 2'd1;
        seq[0] = CH_SEP;
      end else if (incomp_r) begin
        nb     = 2'd1;
        seq[0] = item.ch;
        if (item.ch == CH_SEP) begin
          incomp_nxt = 1'b0;
        end
      end else if (held_r != 2'd0) begin
        priority if (item.ch == CH_SEP) begin
          if (held_r == 2'd2) begin
            if (stk_stat.depth != '0) begin
              pop = 1'b1;
            end else begin
              nb     = 2'd3;
              seq[0] = CH_DOT;
              seq[1] = CH_DOT;
              seq[2] = CH_SEP;
            end
          end
          held_nxt = 2'd0;
        end else if (item.ch == CH_DOT && held_r == 2'd1) begin
          held_nxt = 2'd2;
        end else begin
          if (full) begin
            err_nxt = 1'b1;
          end else begin
            push       = 1'b1;
            incomp_nxt = 1'b1;
            if (held_r == 2'd2) begin
              nb     = 2'd3;
              seq[0] = CH_DOT;
              seq[1] = CH_DOT;
              seq[2] = item.ch;
            end else begin
              nb     = 2'd2;
              seq[0] = CH_DOT;
              seq[1] = item.ch;
            end
          end
          held_nxt = 2'd0;
        end
      end else if (item.ch == CH_SEP) begin
        held_nxt = 2'd0;
      end else if (item.ch == CH_DOT) begin
        held_nxt = 2'd1;
      end else if (full) begin
        err_nxt = 1'b1;
      end else begin
        push       = 1'b1;
        nb         = 2'd1;
        seq[0]     = item.ch;
        incomp_nxt = 1'b1;
      end

      if (item.last_char && !err_nxt && held_nxt != 2'd0) begin
        if (held_nxt == 2'd2) begin
          if (stk_stat.depth != '0) begin
            pop = 1'b1;
          end else begin
            nb         = 2'd2;
            seq[0]     = CH_DOT;
            seq[1]     = CH_DOT;
            incomp_nxt = 1'b1;
          end
        end
        held_nxt = 2'd0;
      end
    end
  end

  assign room     = PTR_W'(MAX_LEN) - wp_r;
  assign ne       = (PTR_W'(nb) > room) ? room[1:0] : nb;
  assign wp_after = pop ? stk_stat.top : wp_r + PTR_W'(ne);
  assign len      = (!incomp_nxt && wp_after > PTR_W'(1)) ? wp_after - PTR_W'(1) : wp_after;

  always_comb begin
    for (int k = 0; k < MAX_RES; k++) begin
      burst.items[k].kind      = KIND_WRITE;
      burst.items[k].position  = POS_W'(wp_r + PTR_W'(k));
      burst.items[k].out_byte  = seq[k];
      burst.items[k].path_done = 1'b0;
      if (RES_CW'(k) == RES_CW'(ne)) begin
        burst.items[k].out_byte  = 8'h00;
        burst.items[k].path_done = 1'b1;
        if (err_nxt) begin
          burst.items[k].kind     = KIND_ERROR;
          burst.items[k].position = '0;
        end else begin
          burst.items[k].kind     = KIND_LENGTH;
          burst.items[k].position = POS_W'(len);
        end
      end
    end
    burst.cnt = go ? RES_CW'(ne) + RES_CW'(item.last_char) : '0;
  end

  assign stk_ctl.push  = go && push;
  assign stk_ctl.pop   = go && pop;
  assign stk_ctl.clear = go && item.last_char;
  assign stk_ctl.val   = wp_r;

  pcan_stack u_stack (
    .clk  (clk),
    .rst_n(rst_n),
    .ctl  (stk_ctl),
    .stat (stk_stat)
  );

  assign wp_nxt = wp_after;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r     <= '0;
      held_r   <= 2'd0;
      incomp_r <= 1'b0;
      start_r  <= 1'b1;
      err_r    <= 1'b0;
    end else if (go) begin
      if (item.last_char) begin
        wp_r     <= '0;
        held_r   <= 2'd0;
        incomp_r <= 1'b0;
        start_r  <= 1'b1;
        err_r    <= 1'b0;
      end else begin
        wp_r     <= wp_nxt;
        held_r   <= held_nxt;
        incomp_r <= incomp_nxt;
        start_r  <= start_nxt;
        err_r    <= err_nxt;
      end
    end
  end

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    stk_ctl.pop |-> stk_stat.depth != '0)
    else $error("pop from empty component stack");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    stk_ctl.push |-> !full && !stk_ctl.pop)
    else $error("push on full stack or with pop");

  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    go && item.last_char |=> start_r && !err_r && wp_r == '0 && stk_stat.depth == '0)
    else $error("path state not cleared after last item");

endmodule

### rtl/pcan_rqueue.sv
// ----------------------------------------------------------------------------
// Result queue
// Takes a burst of up to four result items per cycle and hands them out one
// item per cycle on the output channel while out_stall is low.
// ----------------------------------------------------------------------------
module pcan_rqueue
  import pcan_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  res_burst_t burst,
  output logic       room,
  output logic       out_valid,
  input  logic       out_stall,
  output out_item_t  out_item
);

  out_item_t        q_r [RQ_DEPTH];
  logic [RQ_AW-1:0] head_r;
  logic [RQ_AW-1:0] tail_r;
  logic [RQ_CW-1:0] cnt_r;
  logic [RQ_CW-1:0] cnt_nxt;
  logic             pop;
  logic [RQ_CW-1:0] cnt_left;

  assign out_valid = cnt_r != '0;
  assign out_item  = q_r[head_r];
  assign pop       = out_valid && !out_stall;
  assign cnt_left  = cnt_r - RQ_CW'(pop);
  assign room      = cnt_left <= RQ_CW'(RQ_DEPTH - MAX_RES);
  assign cnt_nxt   = cnt_left + RQ_CW'(burst.cnt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
      cnt_r  <= '0;
    end else begin
      head_r <= head_r + RQ_AW'(pop);
      tail_r <= tail_r + RQ_AW'(burst.cnt);
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < MAX_RES; k++) begin
      if (RES_CW'(k) < burst.cnt) begin
        q_r[RQ_AW'(tail_r + RQ_AW'(k))] <= burst.items[k];
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    burst.cnt != '0 |-> cnt_left + RQ_CW'(burst.cnt) <= RQ_CW'(RQ_DEPTH))
    else $error("result queue overflow");

endmodule

### rtl/path_canonicalizer.sv
// ----------------------------------------------------------------------------
// Lexical path canonicalizer
// Rewrites a byte-serial path: keeps the root slash, collapses separators,
// drops '.', resolves '..', emits buffer writes and final length or error.
// ----------------------------------------------------------------------------
// Flow: an accepted item is registered, then the engine's results for it are
//   written into the result queue, which offers them on the output.
// Throughput: one item per cycle while each item yields at most one result
//   and out_stall is low; bursts of up to four results drain one per cycle.
// Reset: synchronous active-low rst_n clears all control state; the component
//   start memory needs no clearing, as every entry is written before it is read.
// ----------------------------------------------------------------------------
module path_canonicalizer
  import pcan_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  in_item_t   item_r;
  logic       item_v_r;
  logic       room;
  logic       go;
  res_burst_t burst;

  assign go       = item_v_r && room;
  assign in_stall = item_v_r && !room;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_v_r <= 1'b0;
    end else if (in_valid && !in_stall) begin
      item_v_r <= 1'b1;
    end else if (go) begin
      item_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item_r <= in_item;
    end
  end

  pcan_engine u_engine (
    .clk  (clk),
    .rst_n(rst_n),
    .go   (go),
    .item (item_r),
    .burst(burst)
  );

  pcan_rqueue u_rqueue (
    .clk      (clk),
    .rst_n    (rst_n),
    .burst    (burst),
    .room     (room),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item (out_item)
  );

endmodule

### tb/tb_top.sv
// ----------------------------------------------------------------------------
// Path canonicalizer testbench
// Feeds byte-serial paths into the canonicalizer and checks every buffer
// write, final length and overflow error against typed rows or a cycle-free
// predictor. A short directed table comes first, then random paths and deep
// paths that fill and overflow MAX_COMPONENTS. Both channels idle at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;
  import pcan_pkg::*;

  typedef out_item_t [0:MAX_RES-1] res_set_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       last_char;
    logic [2:0] nexp;
    res_set_t   exp;
  } dir_row_t;

  localparam logic [2:0] PREDICT = 3'd7;

  localparam out_item_t NO_R   = '0;
  localparam out_item_t W0_SEP = '{KIND_WRITE, 13'd0, CH_SEP, 1'b0};
  localparam out_item_t W0_DOT = '{KIND_WRITE, 13'd0, CH_DOT, 1'b0};
  localparam out_item_t W1_DOT = '{KIND_WRITE, 13'd1, CH_DOT, 1'b0};
  localparam out_item_t W2_DOT = '{KIND_WRITE, 13'd2, CH_DOT, 1'b0};
  localparam out_item_t W2_SEP = '{KIND_WRITE, 13'd2, CH_SEP, 1'b0};
  localparam out_item_t LEN0   = '{KIND_LENGTH, 13'd0, 8'h00, 1'b1};
  localparam out_item_t LEN1   = '{KIND_LENGTH, 13'd1, 8'h00, 1'b1};
  localparam out_item_t LEN3   = '{KIND_LENGTH, 13'd3, 8'h00, 1'b1};

  localparam int N_DIR = 25;
  localparam dir_row_t DIR_TAB [N_DIR] = '{
    '{CH_SEP, 1'b1, 3'd2,    '{W0_SEP, LEN1, NO_R, NO_R}},
    '{CH_DOT, 1'b1, 3'd1,    '{LEN0, NO_R, NO_R, NO_R}},
    '{CH_SEP, 1'b0, 3'd1,    '{W0_SEP, NO_R, NO_R, NO_R}},
    '{CH_DOT, 1'b0, 3'd0,    '{NO_R, NO_R, NO_R, NO_R}},
    '{CH_DOT, 1'b1, 3'd3,    '{W1_DOT, W2_DOT, LEN3, NO_R}},
    '{CH_DOT, 1'b0, PREDICT, '0},
    '{CH_DOT, 1'b0, PREDICT, '0},
    '{CH_SEP, 1'b0, 3'd3,    '{W0_DOT, W1_DOT, W2_SEP, NO_R}},
    '{"x",    1'b1, PREDICT, '0},
    '{"a",    1'b0, PREDICT, '0},
    '{CH_SEP, 1'b0, PREDICT, '0},
    '{CH_SEP, 1'b0, PREDICT, '0},
    '{CH_DOT, 1'b0, PREDICT, '0},
    '{CH_SEP, 1'b0, PREDICT, '0},
    '{"b",    1'b0, PREDICT, '0},
    '{CH_SEP, 1'b1, PREDICT, '0},
    '{8'h00,  1'b0, PREDICT, '0},
    '{8'hFF,  1'b1, PREDICT, '0},
    '{CH_DOT, 1'b0, PREDICT, '0},
    '{CH_DOT, 1'b0, PREDICT, '0},
    '{"b",    1'b1, PREDICT, '0},
    '{"a",    1'b0, PREDICT, '0},
    '{CH_SEP, 1'b0, PREDICT, '0},
    '{CH_DOT, 1'b0, PREDICT, '0},
    '{CH_DOT, 1'b1, PREDICT, '0}
  };

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_item_t  in_item   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_item;

  bit quiet = 1'b0;
  int mismatch_count = 0;

  out_item_t  canon_q [$];
  out_item_t  item_res [$];
  logic [7:0] path_q [$];

  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   comp_start [MAX_COMPONENTS];
  logic [DEPTH_W-1:0] depth;
  logic [1:0]         dots;
  logic               open_elem;
  logic               path_start;
  logic               overflowed;

  path_canonicalizer uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item (out_item)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #3_000_000;
    $display("TB_ERROR");
    $finish;
  end

  task automatic clear_path();
    wr_ptr     = '0;
    depth      = '0;
    dots       = '0;
    open_elem  = 1'b0;
    path_start = 1'b1;
    overflowed = 1'b0;
  endtask

  task automatic put_char(input logic [7:0] b);
    if (wr_ptr < MAX_LEN) begin
      item_res.push_back('{KIND_WRITE, wr_ptr, b, 1'b0});
      wr_ptr = wr_ptr + 1'b1;
    end
  endtask

  task automatic push_comp(output logic ok);
    if (depth >= MAX_COMPONENTS) begin
      overflowed = 1'b1;
      ok = 1'b0;
    end else begin
      comp_start[depth] = wr_ptr;
      depth = depth + 1'b1;
      ok = 1'b1;
    end
  endtask

  task automatic pop_comp();
    depth  = depth - 1'b1;
    wr_ptr = comp_start[depth];
  endtask

  task automatic rewrite_step(input in_item_t it);
    logic [7:0]       c;
    logic             took;
    logic             ok;
    logic [PTR_W-1:0] len;
    c = it.ch;
    took = 1'b0;
    item_res.delete();
    if (!overflowed) begin
      if (path_start) begin
        path_start = 1'b0;
        if (c == CH_SEP) begin
          put_char(CH_SEP);
          took = 1'b1;
        end
      end
      if (!took) begin
        if (open_elem) begin
          put_char(c);
          if (c == CH_SEP) open_elem = 1'b0;
        end else if (dots != 0) begin
          if (c == CH_SEP) begin
            if (dots == 2) begin
              if (depth > 0) begin
                pop_comp();
              end else begin
                put_char(CH_DOT);
                put_char(CH_DOT);
                put_char(CH_SEP);
              end
            end
            dots = '0;
          end else if (c == CH_DOT && dots == 1) begin
            dots = 2'd2;
          end else begin
            push_comp(ok);
            if (ok) begin
              for (int k = 0; k < dots; k++) put_char(CH_DOT);
              put_char(c);
              open_elem = 1'b1;
            end
            dots = '0;
          end
        end else if (c == CH_DOT) begin
          dots = 2'd1;
        end else if (c != CH_SEP) begin
          push_comp(ok);
          if (ok) begin
            put_char(c);
            open_elem = 1'b1;
          end
        end
      end
      if (it.last_char && !overflowed && dots != 0) begin
        if (dots == 2) begin
          if (depth > 0) begin
            pop_comp();
          end else begin
            put_char(CH_DOT);
            put_char(CH_DOT);
            open_elem = 1'b1;
          end
        end
        dots = '0;
      end
    end
    if (it.last_char) begin
      if (overflowed) begin
        item_res.push_back('{KIND_ERROR, 13'd0, 8'h00, 1'b1});
      end else begin
        len = wr_ptr;
        if (!open_elem && wr_ptr > 1) len = wr_ptr - 1'b1;
        item_res.push_back('{KIND_LENGTH, len, 8'h00, 1'b1});
      end
      clear_path();
    end
  endtask

  task automatic report_mismatch(input string what, input out_item_t got,
                                 input out_item_t want);
    mismatch_count++;
    $display("mismatch (%s): got kind=%0d pos=%0d byte=%h done=%b, %s",
             what, got.kind, got.position, got.out_byte, got.path_done,
             $sformatf("want kind=%0d pos=%0d byte=%h done=%b",
                       want.kind, want.position, want.out_byte, want.path_done));
  endtask

  task automatic send_item(input in_item_t it, input logic [2:0] nexp,
                           input res_set_t typed);
    int gaps;
    gaps = 0;
    if (!quiet) while ($urandom_range(0, 99) < 18) gaps++;
    if (gaps > 0) begin
      in_valid <= 1'b0;
      repeat (gaps) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (in_stall);
    rewrite_step(it);
    if (nexp == PREDICT) begin
      foreach (item_res[k]) canon_q.push_back(item_res[k]);
    end else begin
      for (int k = 0; k < nexp; k++) canon_q.push_back(typed[k]);
    end
  endtask

  task automatic send_path();
    for (int i = 0; i < path_q.size(); i++)
      send_item('{ch: path_q[i], last_char: (i == path_q.size() - 1)}, PREDICT, '0);
  endtask

  function automatic logic [7:0] name_byte();
    logic [7:0] b;
    if ($urandom_range(0, 4) == 0) return CH_DOT;
    do b = 8'($urandom_range(0, 255)); while (b == CH_SEP);
    return b;
  endfunction

  task automatic make_path(input int ncomp, input int maxname);
    int r;
    path_q.delete();
    if ($urandom_range(0, 1)) path_q.push_back(CH_SEP);
    for (int n = 0; n < ncomp; n++) begin
      if (n > 0) path_q.push_back(CH_SEP);
      r = $urandom_range(0, 99);
      if (r < 12) begin
        path_q.push_back(CH_DOT);
      end else if (r < 27) begin
        path_q.push_back(CH_DOT);
        path_q.push_back(CH_DOT);
      end else if (r >= 35) begin
        repeat ($urandom_range(1, maxname)) path_q.push_back(name_byte());
      end
    end
    if ($urandom_range(0, 99) < 30) path_q.push_back(CH_SEP);
    if (path_q.size() == 0) path_q.push_back(name_byte());
  endtask

  task automatic make_noise();
    int r;
    path_q.delete();
    repeat ($urandom_range(1, 8)) begin
      r = $urandom_range(0, 99);
      if (r < 25) path_q.push_back(CH_SEP);
      else if (r < 50) path_q.push_back(CH_DOT);
      else path_q.push_back(8'($urandom_range(0, 255)));
    end
  endtask

  task automatic make_deep_path(input int ncomp);
    logic [7:0] b;
    path_q.delete();
    path_q.push_back(CH_SEP);
    for (int n = 0; n < ncomp; n++) begin
      if (n > 0) path_q.push_back(CH_SEP);
      do b = 8'($urandom_range(0, 255)); while (b == CH_SEP || b == CH_DOT);
      path_q.push_back(b);
    end
  endtask

  always @(posedge clk) out_stall <= !quiet && ($urandom_range(0, 99) < 18);

  always @(posedge clk) begin : check_out
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (canon_q.size() == 0) begin
        report_mismatch("no item expected", out_item, NO_R);
      end else begin
        want = canon_q.pop_front();
        if (out_item.kind !== want.kind) report_mismatch("kind", out_item, want);
        if (out_item.position !== want.position)
          report_mismatch("position", out_item, want);
        if (out_item.out_byte !== want.out_byte)
          report_mismatch("out_byte", out_item, want);
        if (out_item.path_done !== want.path_done)
          report_mismatch("path_done", out_item, want);
      end
    end
  end

  initial begin : stimulus
    int  rand_items;
    bit  paused;
    rand_items = 0;
    paused = 1'b0;
    clear_path();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < N_DIR; i++)
      send_item('{ch: DIR_TAB[i].ch, last_char: DIR_TAB[i].last_char},
                DIR_TAB[i].nexp, DIR_TAB[i].exp);

    while (rand_items < 40) begin
      if (!paused && rand_items >= 10) begin
        paused = 1'b1;
        in_valid <= 1'b0;
        @(posedge clk);
        while (canon_q.size() != 0) @(posedge clk);
      end
      if ($urandom_range(0, 99) < 80) make_path($urandom_range(1, 6), $urandom_range(1, 5));
      else make_noise();
      send_path();
      rand_items += path_q.size();
    end

    quiet = 1'b1;
    make_deep_path(MAX_COMPONENTS);
    send_path();
    quiet = 1'b0;

    make_deep_path(MAX_COMPONENTS + 1);
    path_q.push_back(CH_SEP);
    path_q.push_back(CH_DOT);
    path_q.push_back(CH_DOT);
    send_path();

    make_path(3, 4);
    send_path();

    in_valid <= 1'b0;
    while (canon_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatch_count == 0 && canon_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

### sim.f
rtl/pcan_pkg.sv
rtl/pcan_stack.sv
rtl/pcan_engine.sv
rtl/pcan_rqueue.sv
rtl/path_canonicalizer.sv
tb/tb_top.sv
